// File: rtl/md2_pkg.sv
// ----------------------------------------------------------------------------
// md2_pkg
// Shared types, memory map and the substitution table of the MD2 digest core.
// ----------------------------------------------------------------------------
`default_nettype none

package md2_pkg;

  localparam int RAM_WIDTH = 8;
  localparam int RAM_DEPTH = 64;
  localparam int ADDR_W    = 6;

  // The working memory is split into four 16-byte regions. The chain state
  // and the two scratch regions together form the 48-byte mixing array.
  localparam logic [1:0] REG_CHAIN = 2'd0;
  localparam logic [1:0] REG_BUF   = 2'd1;
  localparam logic [1:0] REG_MIX   = 2'd2;
  localparam logic [1:0] REG_SUM   = 2'd3;

  localparam logic [5:0] LAST_STEP  = 6'd47;
  localparam logic [4:0] LAST_ROUND = 5'd17;
  localparam logic [3:0] LAST_BYTE  = 4'd15;
  localparam logic [4:0] LAST_CLEAR = 5'd31;
  localparam logic [4:0] PAD_FULL   = 5'd16;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PAD,
    S_FOLD0,
    S_FOLD,
    S_ROUND0,
    S_ROUND,
    S_BLKEND,
    S_READ,
    S_RDEND,
    S_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_NORM,
    MD_PAD,
    MD_FIN
  } blk_mode_t;

  // What a memory read returns and what the update stage does with it.
  typedef enum logic [2:0] {
    KIND_PREV,
    KIND_BLK,
    KIND_SUM,
    KIND_HASH,
    KIND_ROUND,
    KIND_DIGEST
  } item_kind_t;

  typedef struct packed {
    logic       vld;
    item_kind_t kind;
    logic [5:0] idx;
    logic [4:0] rnd;
    logic       fin;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01, 8'h3D, 8'h36, 8'h54, 8'hA1,
    8'hEC, 8'hF0, 8'h06, 8'h13, 8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA, 8'h1E, 8'h9B, 8'h57, 8'h3C,
    8'hFD, 8'hD4, 8'hE0, 8'h16, 8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49, 8'hA0, 8'hFB, 8'hF5, 8'h8E,
    8'hBB, 8'h2F, 8'hEE, 8'h7A, 8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21, 8'h80, 8'h7F, 8'h5D, 8'h9A,
    8'h5A, 8'h90, 8'h32, 8'h27, 8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1, 8'hD7, 8'h5E, 8'h92, 8'h2A,
    8'hAC, 8'h56, 8'hAA, 8'hC6, 8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1, 8'h45, 8'h9D, 8'h70, 8'h59,
    8'h64, 8'h71, 8'h87, 8'h20, 8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6, 8'h1C, 8'h46, 8'h61, 8'h69,
    8'h34, 8'h40, 8'h7E, 8'h0F, 8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26, 8'h2C, 8'h53, 8'h0D, 8'h6E,
    8'h85, 8'h28, 8'h84, 8'h09, 8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA, 8'h24, 8'hE1, 8'h7B, 8'h08,
    8'h0C, 8'hBD, 8'hB1, 8'h4A, 8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39, 8'hF2, 8'hEF, 8'hB7, 8'h0E,
    8'h66, 8'h58, 8'hD0, 8'hE4, 8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A, 8'hDB, 8'h99, 8'h8D, 8'h33,
    8'h9F, 8'h11, 8'h83, 8'h14
  };

endpackage

`default_nettype wire

// File: rtl/md2_ram.sv
// ----------------------------------------------------------------------------
// md2_ram
// Generic memory with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module md2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/md2_seq.sv
// ----------------------------------------------------------------------------
// md2_seq
// Sequencer: accepts message bytes, pads, and issues the memory reads of the
// checksum, setup, round and readout passes, each tagged for the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

module md2_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_has,
  input  wire logic              in_last,
  input  wire logic              out_free,
  output logic                   emit,
  output logic [md2_pkg::ADDR_W-1:0] rd_addr,
  output md2_pkg::slot_t         slot,
  output md2_pkg::wr_req_t       wr
);

  md2_pkg::seq_state_t state_r, state_nxt;
  md2_pkg::blk_mode_t  mode_r, mode_nxt;
  md2_pkg::item_kind_t kind_r, kind_nxt;
  md2_pkg::slot_t      slot_r, slot_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic [3:0]          fill_r, fill_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [5:0]          j_r, j_nxt;
  logic [4:0]          r_r, r_nxt;
  logic [4:0]          c_r, c_nxt;
  logic                fin;

  assign fin  = (mode_r == md2_pkg::MD_FIN);
  assign slot = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md2_pkg::S_CLR;
      mode_r      <= md2_pkg::MD_NORM;
      kind_r      <= md2_pkg::KIND_BLK;
      slot_r      <= '0;
      pend_last_r <= 1'b0;
      fill_r      <= '0;
      k_r         <= '0;
      j_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      kind_r      <= kind_nxt;
      slot_r      <= slot_nxt;
      pend_last_r <= pend_last_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    kind_nxt      = kind_r;
    pend_last_nxt = pend_last_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    slot_nxt      = '0;
    slot_nxt.fin  = fin;
    rd_addr       = '0;
    wr            = '0;
    in_ready      = 1'b0;
    emit          = 1'b0;

    case (state_r)
      md2_pkg::S_CLR: begin
        // Zero the chain state and the checksum, one entry a cycle.
        wr.en   = 1'b1;
        wr.addr = {c_r[4], c_r[4], c_r[3:0]};
        wr.data = '0;
        c_nxt   = c_r + 5'd1;
        if (c_r == md2_pkg::LAST_CLEAR) begin
          fill_nxt      = '0;
          pend_last_nxt = 1'b0;
          state_nxt     = md2_pkg::S_IDLE;
        end
      end

      md2_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has) begin
            wr.en   = 1'b1;
            wr.addr = {md2_pkg::REG_BUF, fill_r};
            wr.data = in_byte;
            if (fill_r == md2_pkg::LAST_BYTE) begin
              fill_nxt      = '0;
              pend_last_nxt = in_last;
              mode_nxt      = md2_pkg::MD_NORM;
              state_nxt     = md2_pkg::S_FOLD0;
            end else begin
              fill_nxt = fill_r + 4'd1;
              if (in_last) begin
                k_nxt     = fill_r + 4'd1;
                state_nxt = md2_pkg::S_PAD;
              end
            end
          end else if (in_last) begin
            k_nxt     = fill_r;
            state_nxt = md2_pkg::S_PAD;
          end
        end
      end

      md2_pkg::S_PAD: begin
        wr.en   = 1'b1;
        wr.addr = {md2_pkg::REG_BUF, k_r};
        wr.data = {3'b000, md2_pkg::PAD_FULL - {1'b0, fill_r}};
        k_nxt   = k_r + 4'd1;
        if (k_r == md2_pkg::LAST_BYTE) begin
          mode_nxt  = md2_pkg::MD_PAD;
          state_nxt = md2_pkg::S_FOLD0;
        end
      end

      md2_pkg::S_FOLD0: begin
        // The checksum chain starts from the old last checksum byte.
        rd_addr       = {md2_pkg::REG_SUM, md2_pkg::LAST_BYTE};
        slot_nxt.vld  = 1'b1;
        slot_nxt.kind = md2_pkg::KIND_PREV;
        k_nxt         = '0;
        kind_nxt      = md2_pkg::KIND_BLK;
        state_nxt     = md2_pkg::S_FOLD;
      end

      md2_pkg::S_FOLD: begin
        slot_nxt.vld  = 1'b1;
        slot_nxt.kind = kind_r;
        slot_nxt.idx  = {2'b00, k_r};
        case (kind_r)
          md2_pkg::KIND_BLK: begin
            // The closing block is the checksum itself.
            rd_addr  = fin ? {md2_pkg::REG_SUM, k_r} : {md2_pkg::REG_BUF, k_r};
            kind_nxt = md2_pkg::KIND_SUM;
          end
          md2_pkg::KIND_SUM: begin
            rd_addr  = {md2_pkg::REG_SUM, k_r};
            kind_nxt = md2_pkg::KIND_HASH;
          end
          default: begin
            rd_addr  = {md2_pkg::REG_CHAIN, k_r};
            kind_nxt = md2_pkg::KIND_BLK;
            k_nxt    = k_r + 4'd1;
            if (k_r == md2_pkg::LAST_BYTE) begin
              state_nxt = md2_pkg::S_ROUND0;
            end
          end
        endcase
      end

      md2_pkg::S_ROUND0: begin
        rd_addr       = '0;
        slot_nxt.vld  = 1'b1;
        slot_nxt.kind = md2_pkg::KIND_ROUND;
        j_nxt         = '0;
        r_nxt         = '0;
        state_nxt     = md2_pkg::S_ROUND;
      end

      md2_pkg::S_ROUND: begin
        // Each cycle reads the entry after the one being updated.
        if (j_r == md2_pkg::LAST_STEP && r_r == md2_pkg::LAST_ROUND) begin
          state_nxt = md2_pkg::S_BLKEND;
        end else begin
          if (j_r == md2_pkg::LAST_STEP) begin
            j_nxt = '0;
            r_nxt = r_r + 5'd1;
          end else begin
            j_nxt = j_r + 6'd1;
          end
          rd_addr       = j_nxt;
          slot_nxt.vld  = 1'b1;
          slot_nxt.kind = md2_pkg::KIND_ROUND;
          slot_nxt.idx  = j_nxt;
          slot_nxt.rnd  = r_nxt;
        end
      end

      md2_pkg::S_BLKEND: begin
        case (mode_r)
          md2_pkg::MD_NORM: begin
            if (pend_last_r) begin
              pend_last_nxt = 1'b0;
              k_nxt         = '0;
              state_nxt     = md2_pkg::S_PAD;
            end else begin
              state_nxt = md2_pkg::S_IDLE;
            end
          end
          md2_pkg::MD_PAD: begin
            mode_nxt  = md2_pkg::MD_FIN;
            state_nxt = md2_pkg::S_FOLD0;
          end
          default: begin
            k_nxt     = '0;
            state_nxt = md2_pkg::S_READ;
          end
        endcase
      end

      md2_pkg::S_READ: begin
        rd_addr       = {md2_pkg::REG_CHAIN, k_r};
        slot_nxt.vld  = 1'b1;
        slot_nxt.kind = md2_pkg::KIND_DIGEST;
        k_nxt         = k_r + 4'd1;
        if (k_r == md2_pkg::LAST_BYTE) begin
          state_nxt = md2_pkg::S_RDEND;
        end
      end

      md2_pkg::S_RDEND: begin
        state_nxt = md2_pkg::S_EMIT;
      end

      md2_pkg::S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          c_nxt     = '0;
          mode_nxt  = md2_pkg::MD_NORM;
          state_nxt = md2_pkg::S_CLR;
        end
      end

      default: begin
        c_nxt     = '0;
        state_nxt = md2_pkg::S_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/md2_alu.sv
// ----------------------------------------------------------------------------
// md2_alu
// Update stage: takes each tagged read from the working memory, applies the
// table substitution and returns the write-back; also collects the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module md2_alu (
  input  wire logic             clk,
  input  wire md2_pkg::slot_t   slot,
  input  wire logic [7:0]       rdata,
  output md2_pkg::wr_req_t      wr,
  output logic [127:0]          digest
);

  logic [7:0]   prev_r, prev_nxt;
  logic [7:0]   b_r, b_nxt;
  logic [7:0]   t_r, t_nxt;
  logic [127:0] digest_r, digest_nxt;
  logic [7:0]   sum_new;
  logic [7:0]   rnd_new;

  assign digest = digest_r;

  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    b_r      <= b_nxt;
    t_r      <= t_nxt;
    digest_r <= digest_nxt;
  end

  assign sum_new = rdata ^ md2_pkg::SBOX[b_r ^ prev_r];
  assign rnd_new = rdata ^ md2_pkg::SBOX[t_r];

  always_comb begin
    prev_nxt   = prev_r;
    b_nxt      = b_r;
    t_nxt      = t_r;
    digest_nxt = digest_r;
    wr         = '0;
    if (slot.vld) begin
      case (slot.kind)
        md2_pkg::KIND_PREV: begin
          prev_nxt = rdata;
        end
        md2_pkg::KIND_BLK: begin
          b_nxt = rdata;
        end
        md2_pkg::KIND_SUM: begin
          wr.en = 1'b1;
          if (slot.fin) begin
            // Closing block: copy the checksum into the block region.
            wr.addr = {md2_pkg::REG_BUF, slot.idx[3:0]};
            wr.data = b_r;
          end else begin
            wr.addr  = {md2_pkg::REG_SUM, slot.idx[3:0]};
            wr.data  = sum_new;
            prev_nxt = sum_new;
          end
        end
        md2_pkg::KIND_HASH: begin
          wr.en   = 1'b1;
          wr.addr = {md2_pkg::REG_MIX, slot.idx[3:0]};
          wr.data = rdata ^ b_r;
          t_nxt   = '0;
        end
        md2_pkg::KIND_ROUND: begin
          wr.en   = 1'b1;
          wr.addr = slot.idx;
          wr.data = rnd_new;
          if (slot.idx == md2_pkg::LAST_STEP) begin
            t_nxt = rnd_new + {3'b000, slot.rnd};
          end else begin
            t_nxt = rnd_new;
          end
        end
        md2_pkg::KIND_DIGEST: begin
          digest_nxt = {digest_r[119:0], rdata};
        end
        default: begin
          wr = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/md2_message_digest.sv
// ----------------------------------------------------------------------------
// md2_message_digest
// MD2 hash core. Message bytes arrive one per transaction; tuser marks that
// tdata holds a byte and tlast ends the message, which then yields one result
// transaction with the 128-bit digest. All hash state lives in a 64-byte
// working memory that is read, updated and written back one byte a cycle.
// A byte that does not complete a block is written to the block region and
// leaves the input ready unless it ends the message. A byte that completes
// a 16-byte block holds the input off through a 49-read pass for the checksum
// and the mixing setup, then 18 x 48 = 864 chained table steps through the
// memory's single write port. The end of a message adds up to 16 padding
// bytes, two more block passes, a 16-byte digest readout and a clearing of
// the 32 entries of the chain state and checksum. The same clearing pass
// runs after reset, during which no input is taken. The output register lets
// the next message start while a digest waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module md2_message_digest (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] has_byte
  input  wire logic         in_tlast,   // last_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // [63:0] digest_first, [127:64] digest_second
);

  md2_pkg::slot_t   slot;
  md2_pkg::wr_req_t seq_wr;
  md2_pkg::wr_req_t alu_wr;
  md2_pkg::wr_req_t ram_wr;
  logic [md2_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [127:0]     digest;
  logic             emit;
  logic             out_free;
  logic             out_valid_r;
  logic [127:0]     out_data_r;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sequencer and the update stage never write in the same cycle.
  assign ram_wr = seq_wr.en ? seq_wr : alu_wr;

  md2_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_has   (in_tuser),
    .in_last  (in_tlast),
    .out_free (out_free),
    .emit     (emit),
    .rd_addr  (rd_addr),
    .slot     (slot),
    .wr       (seq_wr)
  );

  md2_ram #(
    .WIDTH (md2_pkg::RAM_WIDTH),
    .DEPTH (md2_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md2_alu u_alu (
    .clk    (clk),
    .slot   (slot),
    .rdata  (rd_data),
    .wr     (alu_wr),
    .digest (digest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {digest[63:0], digest[127:64]};
    end
  end

endmodule

`default_nettype wire
